// ----- rtl/jamc_pkg.sv -----
// ----------------------------------------------------------------------------
// jamc_pkg
// Shared types, register indexes, direction codes and helpers of the
// joystick axis to motor command block.
// ----------------------------------------------------------------------------
package jamc_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int REG_W           = 10;
    localparam int MAPPED_W        = 11;
    localparam int SPEED_W         = 10;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 11;
    localparam int OUT_DATA_W      = 32;
    localparam int QUEUE_DEPTH     = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_SAMPLE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOWEST_SAMPLE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGHEST_SAMPLE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND_LOW   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND_HIGH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAPPED_MIN     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAPPED_MAX     = 3'd6;

    // register reset values
    localparam logic [REG_W-1:0]           CENTER_RST   = 10'd128;
    localparam logic [REG_W-1:0]           LOWEST_RST   = 10'd0;
    localparam logic [REG_W-1:0]           HIGHEST_RST  = 10'd255;
    localparam logic [REG_W-1:0]           DB_LOW_RST   = 10'd120;
    localparam logic [REG_W-1:0]           DB_HIGH_RST  = 10'd136;
    localparam logic signed [MAPPED_W-1:0] MAP_MIN_RST  = -11'sd255;
    localparam logic [REG_W-1:0]           MAP_MAX_RST  = 10'd255;

    // plane direction codes
    localparam logic [2:0] PLANE_STOP     = 3'd0;
    localparam logic [2:0] PLANE_FORWARD  = 3'd1;
    localparam logic [2:0] PLANE_BACKWARD = 3'd2;
    localparam logic [2:0] PLANE_LEFT     = 3'd3;
    localparam logic [2:0] PLANE_RIGHT    = 3'd4;

    // depth direction codes
    localparam logic [1:0] DEPTH_STOP = 2'd0;
    localparam logic [1:0] DEPTH_UP   = 2'd1;
    localparam logic [1:0] DEPTH_DOWN = 2'd2;

    // axis slots of one word
    localparam logic [1:0] AXIS_TURN  = 2'd0;
    localparam logic [1:0] AXIS_SURGE = 2'd1;
    localparam logic [1:0] AXIS_HEAVE = 2'd2;

    typedef struct packed {
        logic [REG_W-1:0]           center_sample;
        logic [REG_W-1:0]           lowest_sample;
        logic [REG_W-1:0]           highest_sample;
        logic [REG_W-1:0]           deadband_low;
        logic [REG_W-1:0]           deadband_high;
        logic signed [MAPPED_W-1:0] mapped_min;
        logic [REG_W-1:0]           mapped_max;
    } cfg_t;

    typedef struct packed {
        logic               changed;
        logic [2:0]         plane_direction;
        logic [SPEED_W-1:0] plane_speed;
        logic [1:0]         depth_direction;
        logic [SPEED_W-1:0] depth_speed;
        logic               toggle_state;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_START,
        ST_WAIT,
        ST_FIX,
        ST_COMMIT
    } back_state_t;

    // magnitude of a mapped value, saturated to the speed range
    function automatic logic [SPEED_W-1:0] speed_of(input logic signed [MAPPED_W-1:0] v);
        logic [MAPPED_W-1:0] m;
        m = v[MAPPED_W-1] ? MAPPED_W'(-v) : MAPPED_W'(v);
        if (m[MAPPED_W-1]) begin
            speed_of = {SPEED_W{1'b1}};
        end else begin
            speed_of = m[SPEED_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/joystick_axis_to_motor_command.sv -----
// ----------------------------------------------------------------------------
// joystick_axis_to_motor_command
// Each word is popped from the queue, then each axis in turn passes the setup, start,
// divider wait and fix states, and the commit state ends the word; an empty segment
// skips the divider, and the commit waits while the output is held by back-pressure.
// The shared one-bit-per-cycle divider maps the three axes in turn, so a new word is
// taken only after the last is committed; a two-word queue takes input meanwhile.
// Reset (aresetn low, synchronous): registers to defaults, state and queue cleared.
// ----------------------------------------------------------------------------
module joystick_axis_to_motor_command #(
    parameter int SAMPLE_BITS = jamc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // turn_sample, surge_sample, heave_sample, button_level, zero fill
    input  logic [((3*SAMPLE_BITS+8)/8)*8-1:0]    s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // plane_direction, plane_speed, depth_direction, depth_speed, toggle_state, zero fill
    output logic [jamc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // changed
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_wr_en,
    input  logic [jamc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [jamc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int IN_DATA_W = ((3 * SAMPLE_BITS + 8) / 8) * 8;
    localparam int ITW       = 3 * SAMPLE_BITS + 1;
    localparam int RES_W     = $bits(jamc_pkg::result_t) - 1;

    jamc_pkg::cfg_t    cfg_reg;
    jamc_pkg::result_t res;
    logic              q_push;
    logic [ITW-1:0]    q_wdata;
    logic              q_full;
    logic              q_pop;
    logic [ITW-1:0]    q_rdata;
    logic              q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_sample  <= jamc_pkg::CENTER_RST;
            cfg_reg.lowest_sample  <= jamc_pkg::LOWEST_RST;
            cfg_reg.highest_sample <= jamc_pkg::HIGHEST_RST;
            cfg_reg.deadband_low   <= jamc_pkg::DB_LOW_RST;
            cfg_reg.deadband_high  <= jamc_pkg::DB_HIGH_RST;
            cfg_reg.mapped_min     <= jamc_pkg::MAP_MIN_RST;
            cfg_reg.mapped_max     <= jamc_pkg::MAP_MAX_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                jamc_pkg::REG_CENTER_SAMPLE:  cfg_reg.center_sample  <= cfg_wdata[9:0];
                jamc_pkg::REG_LOWEST_SAMPLE:  cfg_reg.lowest_sample  <= cfg_wdata[9:0];
                jamc_pkg::REG_HIGHEST_SAMPLE: cfg_reg.highest_sample <= cfg_wdata[9:0];
                jamc_pkg::REG_DEADBAND_LOW:   cfg_reg.deadband_low   <= cfg_wdata[9:0];
                jamc_pkg::REG_DEADBAND_HIGH:  cfg_reg.deadband_high  <= cfg_wdata[9:0];
                jamc_pkg::REG_MAPPED_MIN:     cfg_reg.mapped_min     <= $signed(cfg_wdata);
                jamc_pkg::REG_MAPPED_MAX:     cfg_reg.mapped_max     <= cfg_wdata[9:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    jamc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_DATA_W   (IN_DATA_W)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    jamc_queue #(
        .WIDTH (ITW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    jamc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.changed;
    assign m_axis_tdata = {(jamc_pkg::OUT_DATA_W - RES_W)'(0),
                           res.toggle_state, res.depth_speed, res.depth_direction,
                           res.plane_speed, res.plane_direction};

endmodule

// ----- rtl/jamc_queue.sv -----
// ----------------------------------------------------------------------------
// jamc_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module jamc_queue #(
    parameter int WIDTH = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int DEPTH = jamc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/jamc_front.sv -----
// ----------------------------------------------------------------------------
// jamc_front
// Input side: takes words from the slave stream, pulls samples inside the
// deadband to the center value and pushes them into the queue.
// ----------------------------------------------------------------------------
module jamc_front #(
    parameter int SAMPLE_BITS = jamc_pkg::SAMPLE_BITS_DEF,
    parameter int IN_DATA_W   = 32
) (
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_W-1:0]     s_axis_tdata,
    input  jamc_pkg::cfg_t           cfg,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [3*SAMPLE_BITS:0]   q_data
);

    localparam int SW = SAMPLE_BITS;

    logic [SW-1:0] center;
    logic [SW-1:0] db_low;
    logic [SW-1:0] db_high;
    logic [SW-1:0] raw     [3];
    logic [SW-1:0] cleaned [3];

    assign center  = SW'(cfg.center_sample);
    assign db_low  = SW'(cfg.deadband_low);
    assign db_high = SW'(cfg.deadband_high);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            raw[i] = s_axis_tdata[i*SW +: SW];
            // snap to center when strictly inside the deadband
            cleaned[i] = (raw[i] < db_high && raw[i] > db_low) ? center : raw[i];
        end
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign q_data        = {s_axis_tdata[3*SW], cleaned[2], cleaned[1], cleaned[0]};

endmodule

// ----- rtl/jamc_divider.sv -----
// ----------------------------------------------------------------------------
// jamc_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jamc_divider #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign fits     = (shifted >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/jamc_back.sv -----
// ----------------------------------------------------------------------------
// jamc_back
// Work side: maps the three axes one after another through a shared
// multiplier and divider, tracks the stored state and drives the result
// register.
// ----------------------------------------------------------------------------
module jamc_back #(
    parameter int SAMPLE_BITS = jamc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  logic [3*SAMPLE_BITS:0] q_data,
    output logic                   q_pop,
    input  jamc_pkg::cfg_t         cfg,
    output logic                   res_valid,
    input  logic                   res_ready,
    output jamc_pkg::result_t      res
);

    localparam int SW  = SAMPLE_BITS;
    localparam int MW  = jamc_pkg::MAPPED_W;
    localparam int PW  = SW + 13;   // signed product
    localparam int QW  = SW + 10;   // quotient magnitude
    localparam int VW  = SW + 12;   // signed mapped value before saturation
    localparam int ITW = 3 * SW + 1;

    jamc_pkg::back_state_t state_reg, state_next;

    logic [ITW-1:0]        item_reg;
    logic [1:0]            axis_reg;
    logic                  ge_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [SW:0]    dvs_reg;
    logic                  neg_reg;
    logic                  dzero_reg;
    logic signed [MW-1:0]  mapped_reg [3];
    logic signed [MW-1:0]  last_reg   [3];
    logic                  last_button_reg;
    logic                  toggle_reg;
    logic [2:0]            plane_dir_reg;
    logic [9:0]            plane_speed_reg;
    logic [1:0]            depth_dir_reg;
    logic [9:0]            depth_speed_reg;
    logic                  out_valid_reg;
    jamc_pkg::result_t     res_reg;

    // setup path
    logic [SW-1:0]         x;
    logic [SW-1:0]         c;
    logic [SW-1:0]         lo;
    logic [SW-1:0]         hi;
    logic signed [SW:0]    x_s, c_s, lo_s, hi_s;
    logic signed [11:0]    mn_ext;
    logic                  ge_next;
    logic signed [SW:0]    a_next;
    logic signed [11:0]    b_next;
    logic signed [SW:0]    dvs_next;
    logic signed [PW-1:0]  prod_next;

    // divider
    logic [PW-1:0]         prod_mag;
    logic [SW:0]           dvs_mag;
    logic                  div_start;
    logic                  div_done;
    logic [QW-1:0]         div_quo;

    // fix path
    logic signed [VW-1:0]  val;
    logic signed [VW-1:0]  mn_v;
    logic signed [VW-1:0]  mx_v;
    logic signed [MW-1:0]  fix_val;

    // commit path
    logic                  can_out;
    logic                  any_change;
    logic                  rise;
    logic                  toggle_next;
    logic [2:0]            plane_dir_next;
    logic [9:0]            plane_speed_next;
    logic [1:0]            depth_dir_next;
    logic [9:0]            depth_speed_next;

    // ---------------- setup: operands and product ----------------
    always_comb begin
        case (axis_reg)
            jamc_pkg::AXIS_TURN:  x = item_reg[SW-1:0];
            jamc_pkg::AXIS_SURGE: x = item_reg[2*SW-1:SW];
            default:              x = item_reg[3*SW-1:2*SW];
        endcase
        c      = SW'(cfg.center_sample);
        lo     = SW'(cfg.lowest_sample);
        hi     = SW'(cfg.highest_sample);
        x_s    = $signed({1'b0, x});
        c_s    = $signed({1'b0, c});
        lo_s   = $signed({1'b0, lo});
        hi_s   = $signed({1'b0, hi});
        mn_ext = {cfg.mapped_min[MW-1], cfg.mapped_min};
        ge_next = (x >= c);
        if (ge_next) begin
            a_next   = x_s - c_s;
            b_next   = $signed({2'b00, cfg.mapped_max});
            dvs_next = hi_s - c_s;
        end else begin
            a_next   = x_s - lo_s;
            b_next   = -mn_ext;
            dvs_next = c_s - lo_s;
        end
        prod_next = a_next * b_next;
    end

    assign prod_mag = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign dvs_mag  = dvs_reg[SW] ? (SW+1)'(-dvs_reg) : (SW+1)'(dvs_reg);

    jamc_divider #(
        .DIVIDEND_W (QW),
        .DIVISOR_W  (SW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_mag[QW-1:0]),
        .divisor  (dvs_mag[SW-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------- fix: sign, offset, saturation ----------------
    always_comb begin
        mn_v = VW'(cfg.mapped_min);
        mx_v = $signed(VW'(cfg.mapped_max));
        val  = $signed({2'b00, div_quo});
        if (neg_reg) begin
            val = -val;
        end
        if (!ge_reg) begin
            val = val + mn_v;
        end
        // an empty segment maps to center, without the lower offset
        if (dzero_reg) begin
            val = '0;
        end
        // upper limit first, so an inverted range ends at mapped_min
        if (val > mx_v) begin
            val = mx_v;
        end
        if (val < mn_v) begin
            val = mn_v;
        end
        fix_val = val[MW-1:0];
    end

    // ---------------- commit: change detect and decode ----------------
    always_comb begin
        any_change  = (mapped_reg[0] != last_reg[0]) || (mapped_reg[1] != last_reg[1])
                   || (mapped_reg[2] != last_reg[2]);
        rise        = item_reg[3*SW] && !last_button_reg;
        toggle_next = toggle_reg ^ rise;

        plane_dir_next   = plane_dir_reg;
        plane_speed_next = plane_speed_reg;
        depth_dir_next   = depth_dir_reg;
        depth_speed_next = depth_speed_reg;
        if (any_change) begin
            // surge wins over turn
            if (mapped_reg[1] < 0) begin
                plane_dir_next   = jamc_pkg::PLANE_FORWARD;
                plane_speed_next = jamc_pkg::speed_of(mapped_reg[1]);
            end else if (mapped_reg[1] > 0) begin
                plane_dir_next   = jamc_pkg::PLANE_BACKWARD;
                plane_speed_next = jamc_pkg::speed_of(mapped_reg[1]);
            end else if (mapped_reg[0] < 0) begin
                plane_dir_next   = jamc_pkg::PLANE_LEFT;
                plane_speed_next = jamc_pkg::speed_of(mapped_reg[0]);
            end else if (mapped_reg[0] > 0) begin
                plane_dir_next   = jamc_pkg::PLANE_RIGHT;
                plane_speed_next = jamc_pkg::speed_of(mapped_reg[0]);
            end else begin
                plane_dir_next   = jamc_pkg::PLANE_STOP;
                plane_speed_next = '0;
            end
            if (mapped_reg[2] < 0) begin
                depth_dir_next   = jamc_pkg::DEPTH_UP;
                depth_speed_next = jamc_pkg::speed_of(mapped_reg[2]);
            end else if (mapped_reg[2] > 0) begin
                depth_dir_next   = jamc_pkg::DEPTH_DOWN;
                depth_speed_next = jamc_pkg::speed_of(mapped_reg[2]);
            end else begin
                depth_dir_next   = jamc_pkg::DEPTH_STOP;
                depth_speed_next = '0;
            end
        end
    end

    assign can_out = !out_valid_reg || res_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            jamc_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = jamc_pkg::ST_SETUP;
                end
            end
            jamc_pkg::ST_SETUP: begin
                state_next = jamc_pkg::ST_START;
            end
            jamc_pkg::ST_START: begin
                // skip the divider on an empty segment
                if (dvs_reg == '0) begin
                    state_next = jamc_pkg::ST_FIX;
                end else begin
                    div_start  = 1'b1;
                    state_next = jamc_pkg::ST_WAIT;
                end
            end
            jamc_pkg::ST_WAIT: begin
                if (div_done) begin
                    state_next = jamc_pkg::ST_FIX;
                end
            end
            jamc_pkg::ST_FIX: begin
                state_next = (axis_reg == jamc_pkg::AXIS_HEAVE) ? jamc_pkg::ST_COMMIT
                                                                : jamc_pkg::ST_SETUP;
            end
            jamc_pkg::ST_COMMIT: begin
                if (can_out) begin
                    state_next = jamc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jamc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jamc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // payload datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            jamc_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    item_reg <= q_data;
                end
            end
            jamc_pkg::ST_SETUP: begin
                ge_reg   <= ge_next;
                prod_reg <= prod_next;
                dvs_reg  <= dvs_next;
            end
            jamc_pkg::ST_START: begin
                neg_reg   <= prod_reg[PW-1] ^ dvs_reg[SW];
                dzero_reg <= (dvs_reg == '0);
            end
            jamc_pkg::ST_FIX: begin
                mapped_reg[axis_reg] <= fix_val;
            end
            jamc_pkg::ST_COMMIT: begin
                if (can_out) begin
                    res_reg.changed         <= any_change || rise;
                    res_reg.plane_direction <= plane_dir_next;
                    res_reg.plane_speed     <= plane_speed_next;
                    res_reg.depth_direction <= depth_dir_next;
                    res_reg.depth_speed     <= depth_speed_next;
                    res_reg.toggle_state    <= toggle_next;
                end
            end
            default: begin
            end
        endcase
    end

    // stored state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg        <= jamc_pkg::AXIS_TURN;
            out_valid_reg   <= 1'b0;
            last_reg[0]     <= '0;
            last_reg[1]     <= '0;
            last_reg[2]     <= '0;
            last_button_reg <= 1'b0;
            toggle_reg      <= 1'b0;
            plane_dir_reg   <= jamc_pkg::PLANE_STOP;
            plane_speed_reg <= '0;
            depth_dir_reg   <= jamc_pkg::DEPTH_STOP;
            depth_speed_reg <= '0;
        end else begin
            if (state_reg == jamc_pkg::ST_IDLE) begin
                axis_reg <= jamc_pkg::AXIS_TURN;
            end else if (state_reg == jamc_pkg::ST_FIX) begin
                axis_reg <= axis_reg + 1'b1;
            end
            if (state_reg == jamc_pkg::ST_COMMIT && can_out) begin
                out_valid_reg   <= 1'b1;
                last_reg[0]     <= mapped_reg[0];
                last_reg[1]     <= mapped_reg[1];
                last_reg[2]     <= mapped_reg[2];
                last_button_reg <= item_reg[3*SW];
                toggle_reg      <= toggle_next;
                plane_dir_reg   <= plane_dir_next;
                plane_speed_reg <= plane_speed_next;
                depth_dir_reg   <= depth_dir_next;
                depth_speed_reg <= depth_speed_next;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule
